@@ sv/tsm_pkg.sv @@
// shared types and constants for the crate stream timestamp merge
`default_nettype none
package tsm_pkg;

  localparam int MAX_CRATES = 8;
  localparam int CRATE_BITS = 3;
  localparam int COUNT_BITS = 4;
  localparam int TS_BITS    = 48;
  localparam int TIME_BITS  = 52;
  localparam int TAG_BITS   = 32;
  localparam int RATE_BITS  = 2;

  localparam logic [COUNT_BITS-1:0] CRATES_RESET = 4'd8;
  localparam logic [COUNT_BITS-1:0] CRATES_MAX   = 4'd8;

  localparam logic REQ_HIT = 1'b0;
  localparam logic REQ_END = 1'b1;

  localparam logic [RATE_BITS-1:0] RATE_100 = 2'd0;
  localparam logic [RATE_BITS-1:0] RATE_250 = 2'd1;
  localparam logic [RATE_BITS-1:0] RATE_500 = 2'd2;
  localparam logic [RATE_BITS-1:0] RATE_UNK = 2'd3;

  localparam logic STATUS_EMIT   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [CRATE_BITS-1:0] crate;
    logic [RATE_BITS-1:0]  rate_code;
    logic [TS_BITS-1:0]    raw_timestamp;
    logic [TAG_BITS-1:0]   event_tag;
  } in_req_t;

  typedef struct packed {
    logic                  status;
    logic [CRATE_BITS-1:0] out_crate;
    logic [RATE_BITS-1:0]  out_rate;
    logic [TIME_BITS-1:0]  time_ns;
    logic [TAG_BITS-1:0]   out_tag;
    logic                  last;
  } out_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT,
    ST_EMIT
  } st_t;

  typedef struct packed {
    logic clear;
    logic step;
  } minu_ctl_t;

  typedef struct packed {
    logic                  valid;
    logic                  ended;
    logic [CRATE_BITS-1:0] crate;
    logic [TIME_BITS-1:0]  time_ns;
    logic [TAG_BITS-1:0]   tag;
    logic [RATE_BITS-1:0]  rate;
  } scan_elem_t;

  typedef struct packed {
    logic                  ready;
    logic                  any;
    logic [CRATE_BITS-1:0] crate;
    logic [TIME_BITS-1:0]  time_ns;
    logic [TAG_BITS-1:0]   tag;
    logic [RATE_BITS-1:0]  rate;
  } min_res_t;

endpackage
`default_nettype wire

@@ sv/tsm_min_unit.sv @@
// shared compare unit that finds the earliest head over a crate scan
`default_nettype none
module tsm_min_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tsm_pkg::minu_ctl_t ctl,
  input  wire tsm_pkg::scan_elem_t elem,
  output tsm_pkg::min_res_t      res
);
  import tsm_pkg::*;

  logic                  ready_r, ready_nxt;
  logic                  any_r, any_nxt;
  logic [CRATE_BITS-1:0] crate_r, crate_nxt;
  logic [TIME_BITS-1:0]  time_r, time_nxt;
  logic [TAG_BITS-1:0]   tag_r, tag_nxt;
  logic [RATE_BITS-1:0]  rate_r, rate_nxt;
  logic                  take;

  assign take = elem.valid && (!any_r || (elem.time_ns < time_r));

  always_comb begin
    ready_nxt = ready_r;
    any_nxt   = any_r;
    crate_nxt = crate_r;
    time_nxt  = time_r;
    tag_nxt   = tag_r;
    rate_nxt  = rate_r;
    if (ctl.clear) begin
      ready_nxt = 1'b1;
      any_nxt   = 1'b0;
    end else if (ctl.step) begin
      ready_nxt = ready_r && (elem.valid || elem.ended);
      any_nxt   = any_r || elem.valid;
      if (take) begin
        crate_nxt = elem.crate;
        time_nxt  = elem.time_ns;
        tag_nxt   = elem.tag;
        rate_nxt  = elem.rate;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b1;
      any_r   <= 1'b0;
    end else begin
      ready_r <= ready_nxt;
      any_r   <= any_nxt;
    end
    crate_r <= crate_nxt;
    time_r  <= time_nxt;
    tag_r   <= tag_nxt;
    rate_r  <= rate_nxt;
  end

  assign res.ready   = ready_r;
  assign res.any     = any_r;
  assign res.crate   = crate_r;
  assign res.time_ns = time_r;
  assign res.tag     = tag_r;
  assign res.rate    = rate_r;

endmodule
`default_nettype wire

@@ sv/timestamp_merge_of_crate_streams.sv @@
// top level of the time-ordered merge of crate hit streams
// Usage:
//   Requests enter on in_item when start is high and busy is low. A request
//   is a hit or an end-of-stream marker for one crate. A hit becomes that
//   crate's head with its timestamp scaled to nanoseconds.
//   Results leave on out_res for one cycle each, marked by out_strobe; the
//   receiver cannot stall them. A rejected hit gives a reject result first;
//   then, when every active crate holds a head or has ended, the earliest
//   head (lowest crate on ties) is emitted. last marks a request's final
//   result; a request may give no result at all. cfg_we/cfg_wdata write the
//   active crate count; the user must do so only while idle (not enforced).
// Timing:
//   the request is taken in ST_IDLE, then each active crate in turn passes
//   through the shared compare unit in ST_SCAN, then ST_OUT gives the first
//   result, if any, with ST_EMIT added when a reject and an emission both
//   follow. A new request is taken only once the block is back in ST_IDLE.
//   busy drops as the last result goes onto the output register, so the
//   next request may enter while that result is shown.
// Reset:
//   clears all heads and end marks and sets the crate count to eight.
`default_nettype none
module timestamp_merge_of_crate_streams (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire tsm_pkg::in_req_t  in_item,
  output logic                   out_strobe,
  output tsm_pkg::out_res_t      out_res,
  input  wire logic              cfg_we,
  input  wire logic [3:0]        cfg_wdata
);
  import tsm_pkg::*;

  st_t                   state_r, state_nxt;
  logic [COUNT_BITS-1:0] cfg_r, cfg_nxt;
  logic [COUNT_BITS-1:0] n_r, n_nxt;
  logic [CRATE_BITS-1:0] idx_r, idx_nxt;
  logic                  rej_r, rej_nxt;
  logic [CRATE_BITS-1:0] rej_crate_r, rej_crate_nxt;
  logic [RATE_BITS-1:0]  rej_rate_r, rej_rate_nxt;
  logic [TIME_BITS-1:0]  rej_time_r, rej_time_nxt;
  logic [TAG_BITS-1:0]   rej_tag_r, rej_tag_nxt;
  logic                  strobe_r, strobe_nxt;
  out_res_t              res_r, res_nxt;

  logic [MAX_CRATES-1:0] valid_r, valid_nxt;
  logic [MAX_CRATES-1:0] ended_r, ended_nxt;
  logic [TIME_BITS-1:0]  head_time_r [MAX_CRATES];
  logic [TAG_BITS-1:0]   head_tag_r  [MAX_CRATES];
  logic [RATE_BITS-1:0]  head_rate_r [MAX_CRATES];
  logic                  head_we;

  logic [COUNT_BITS-1:0] n_eff;
  logic                  accept;
  logic                  in_active;
  logic                  in_reject;
  logic [TIME_BITS-1:0]  in_time;
  logic                  do_emit;

  minu_ctl_t             mctl;
  scan_elem_t            melem;
  min_res_t              mres;

  function automatic logic [TIME_BITS-1:0] scale_time(
    input logic [RATE_BITS-1:0] rate,
    input logic [TS_BITS-1:0]   ts
  );
    logic [TIME_BITS-1:0] wide;
    logic [TIME_BITS-1:0] t;
    wide = {{(TIME_BITS-TS_BITS){1'b0}}, ts};
    case (rate)
      RATE_100, RATE_500: t = (wide << 3) + (wide << 1);
      RATE_250:           t = wide << 3;
      default:            t = '0;
    endcase
    return t;
  endfunction

  always_comb begin
    if (cfg_r == '0) n_eff = {{(COUNT_BITS-1){1'b0}}, 1'b1};
    else if (cfg_r > CRATES_MAX) n_eff = CRATES_MAX;
    else n_eff = cfg_r;
  end

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign in_active = ({1'b0, in_item.crate} < n_eff);
  assign in_time   = scale_time(in_item.rate_code, in_item.raw_timestamp);
  assign in_reject = !in_active || (in_item.rate_code == RATE_UNK) ||
                     valid_r[in_item.crate] || ended_r[in_item.crate];
  assign do_emit   = mres.ready && mres.any;

  assign melem.valid   = valid_r[idx_r];
  assign melem.ended   = ended_r[idx_r];
  assign melem.crate   = idx_r;
  assign melem.time_ns = head_time_r[idx_r];
  assign melem.tag     = head_tag_r[idx_r];
  assign melem.rate    = head_rate_r[idx_r];

  tsm_min_unit u_min (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mctl),
    .elem  (melem),
    .res   (mres)
  );

  always_comb begin
    state_nxt     = state_r;
    cfg_nxt       = cfg_we ? cfg_wdata : cfg_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    rej_nxt       = rej_r;
    rej_crate_nxt = rej_crate_r;
    rej_rate_nxt  = rej_rate_r;
    rej_time_nxt  = rej_time_r;
    rej_tag_nxt   = rej_tag_r;
    strobe_nxt    = 1'b0;
    res_nxt       = res_r;
    valid_nxt     = valid_r;
    ended_nxt     = ended_r;
    head_we       = 1'b0;
    mctl.clear    = 1'b0;
    mctl.step     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          n_nxt         = n_eff;
          idx_nxt       = '0;
          mctl.clear    = 1'b1;
          rej_crate_nxt = in_item.crate;
          rej_rate_nxt  = in_item.rate_code;
          rej_time_nxt  = in_time;
          rej_tag_nxt   = in_item.event_tag;
          rej_nxt       = 1'b0;
          if (in_item.req_type == REQ_END) begin
            if (in_active) ended_nxt[in_item.crate] = 1'b1;
          end else if (in_reject) begin
            rej_nxt = 1'b1;
          end else begin
            valid_nxt[in_item.crate] = 1'b1;
            head_we = 1'b1;
          end
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        mctl.step = 1'b1;
        idx_nxt   = idx_r + 1'b1;
        if ({1'b0, idx_r} == n_r - 1'b1) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (rej_r) begin
          strobe_nxt        = 1'b1;
          res_nxt.status    = STATUS_REJECT;
          res_nxt.out_crate = rej_crate_r;
          res_nxt.out_rate  = rej_rate_r;
          res_nxt.time_ns   = rej_time_r;
          res_nxt.out_tag   = rej_tag_r;
          res_nxt.last      = !do_emit;
          rej_nxt           = 1'b0;
          state_nxt         = do_emit ? ST_EMIT : ST_IDLE;
        end else begin
          if (do_emit) begin
            strobe_nxt        = 1'b1;
            res_nxt.status    = STATUS_EMIT;
            res_nxt.out_crate = mres.crate;
            res_nxt.out_rate  = mres.rate;
            res_nxt.time_ns   = mres.time_ns;
            res_nxt.out_tag   = mres.tag;
            res_nxt.last      = 1'b1;
            valid_nxt[mres.crate] = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        strobe_nxt        = 1'b1;
        res_nxt.status    = STATUS_EMIT;
        res_nxt.out_crate = mres.crate;
        res_nxt.out_rate  = mres.rate;
        res_nxt.time_ns   = mres.time_ns;
        res_nxt.out_tag   = mres.tag;
        res_nxt.last      = 1'b1;
        valid_nxt[mres.crate] = 1'b0;
        state_nxt         = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cfg_r    <= CRATES_RESET;
      n_r      <= CRATES_RESET;
      idx_r    <= '0;
      rej_r    <= 1'b0;
      strobe_r <= 1'b0;
      valid_r  <= '0;
      ended_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      cfg_r    <= cfg_nxt;
      n_r      <= n_nxt;
      idx_r    <= idx_nxt;
      rej_r    <= rej_nxt;
      strobe_r <= strobe_nxt;
      valid_r  <= valid_nxt;
      ended_r  <= ended_nxt;
    end
    rej_crate_r <= rej_crate_nxt;
    rej_rate_r  <= rej_rate_nxt;
    rej_time_r  <= rej_time_nxt;
    rej_tag_r   <= rej_tag_nxt;
    res_r       <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_time_r[in_item.crate] <= in_time;
      head_tag_r[in_item.crate]  <= in_item.event_tag;
      head_rate_r[in_item.crate] <= in_item.rate_code;
    end
  end

  assign out_strobe = strobe_r;
  assign out_res    = res_r;

  // a reject that is not last is followed directly by its emission
  a_reject_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && !res_r.last) |=>
      (strobe_r && res_r.status == STATUS_EMIT && res_r.last))
    else $error("reject not followed by emission");

  // an emitted crate has its head slot freed
  a_emit_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && res_r.status == STATUS_EMIT) |-> !valid_r[res_r.out_crate])
    else $error("emitted head still valid");

  // emissions only come from active crates
  a_emit_active: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && res_r.status == STATUS_EMIT) |->
      ({1'b0, res_r.out_crate} < n_r))
    else $error("emission from inactive crate");

  // the scan index stays below the latched crate count
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ({1'b0, idx_r} < n_r))
    else $error("scan index out of range");

endmodule
`default_nettype wire
